[hdl/ttw_pkg.sv]
// ----------------------------------------------------------------------------
// ttw_pkg
// Types and constants shared by the text terminal writer and its register file.
// ----------------------------------------------------------------------------
package ttw_pkg;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int PADDR_W = 4;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_COLOUR  = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  BLANK_GLYPH  = 8'h20;
  localparam logic [15:0] RESET_CELL   = 16'h0720;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET    = 7'd25;
  localparam logic [7:0] COLOUR_RESET  = 8'd7;

  typedef struct packed {
    logic [7:0] cols;
    logic [6:0] rows;
    logic [7:0] colour;
  } cfg_t;

endpackage

[hdl/ttw_ram.sv]
// ----------------------------------------------------------------------------
// ttw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ttw_regs.sv]
// ----------------------------------------------------------------------------
// ttw_regs
// APB register file: column count, row count and text colour, with the
// effective (clamped) screen dimensions presented to the core.
// ----------------------------------------------------------------------------
module ttw_regs #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ttw_pkg::cfg_t               cfg
);

  logic [7:0] columns_in_use;
  logic [6:0] rows_in_use;
  logic [7:0] text_colour;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= ttw_pkg::COLUMNS_RESET;
      rows_in_use    <= ttw_pkg::ROWS_RESET;
      text_colour    <= ttw_pkg::COLOUR_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        ttw_pkg::REG_COLUMNS: columns_in_use <= pwdata[7:0];
        ttw_pkg::REG_ROWS:    rows_in_use    <= pwdata[6:0];
        ttw_pkg::REG_COLOUR:  text_colour    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ttw_pkg::REG_COLUMNS: prdata = {24'd0, columns_in_use};
      ttw_pkg::REG_ROWS:    prdata = {25'd0, rows_in_use};
      ttw_pkg::REG_COLOUR:  prdata = {24'd0, text_colour};
      default:              prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (columns_in_use == 8'd0) begin
      cfg.cols = 8'd1;
    end else if (32'(columns_in_use) > MAX_COLS) begin
      cfg.cols = 8'(MAX_COLS);
    end else begin
      cfg.cols = columns_in_use;
    end
    if (rows_in_use == 7'd0) begin
      cfg.rows = 7'd1;
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      cfg.rows = 7'(MAX_ROWS);
    end else begin
      cfg.rows = rows_in_use;
    end
    cfg.colour = text_colour;
  end

endmodule

[hdl/text_terminal_writer.sv]
// ----------------------------------------------------------------------------
// text_terminal_writer
// Text-mode character store with cursor: put, newline, scroll, clear, read.
//
// Commands arrive on in_valid/in_ready; one result transaction per command
// leaves on out_valid/out_ready through an output register. The APB port sets
// column count, row count and colour; write it only while the block is idle,
// and follow any dimension change with a clear.
// A put or newline registers its result at once.
// A read first reads the store, then registers the cell in ST_RDW.
// A put that scrolls posts its result at once, then holds in_ready low while
// it copies rows up and blanks the bottom row, one cell per cycle, set by the
// single store port pair. A clear walks the whole store.
// After reset the store is initialized to 0x0720 by a sweep of the whole
// store with in_ready low; APB writes are taken meanwhile.
// A command is accepted only when the output register is empty or being
// emptied, so a stalled receiver stalls the input side.
// ----------------------------------------------------------------------------
module text_terminal_writer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [7:0]                  char_code,
  input  logic [5:0]                  read_row,
  input  logic [6:0]                  read_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 cell_value,
  output logic [5:0]                  cursor_row_out,
  output logic [6:0]                  cursor_col_out,
  output logic                        scrolled
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] LAST_ADDR = CW'(DEPTH - 1);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RDW   = 6'b000100,
    ST_COPY  = 6'b001000,
    ST_FILL  = 6'b010000,
    ST_CLEAR = 6'b100000
  } state_t;

  ttw_pkg::cfg_t cfg;

  state_t                      state;
  logic [ttw_pkg::ROW_W-1:0]   cursor_row;
  logic [ttw_pkg::COL_W-1:0]   cursor_col;
  logic [CW-1:0]               cp_src;
  logic [CW-1:0]               cp_dst;
  logic                        cp_pend;
  logic [CW-1:0]               total;
  logic [15:0]                 fill_cell;
  logic                        read_ok;

  logic                        accept;
  logic                        is_newline;
  logic [7:0]                  col_inc;
  logic [6:0]                  row_inc;
  logic                        wrap;
  logic                        scroll;
  logic [ttw_pkg::ROW_W-1:0]   row_next;
  logic [ttw_pkg::COL_W-1:0]   col_next;
  logic                        in_screen;
  logic                        rd_in_screen;
  logic [CW-1:0]               put_addr;
  logic [CW-1:0]               rd_addr;
  logic                        issue;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [15:0]                 ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [15:0]                 ram_rdata;

  ttw_regs #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  ttw_ram #(
    .WIDTH(ttw_pkg::CELL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_newline   = (char_code == ttw_pkg::NEWLINE_CODE);
    col_inc      = {1'b0, cursor_col} + 8'd1;
    row_inc      = {1'b0, cursor_row} + 7'd1;
    wrap         = is_newline || (col_inc >= cfg.cols);
    scroll       = wrap && (row_inc >= cfg.rows);
    col_next     = wrap ? '0 : col_inc[ttw_pkg::COL_W-1:0];
    if (!wrap) begin
      row_next = cursor_row;
    end else if (scroll) begin
      row_next = ttw_pkg::ROW_W'(cfg.rows - 7'd1);
    end else begin
      row_next = row_inc[ttw_pkg::ROW_W-1:0];
    end
    in_screen    = ({1'b0, cursor_row} < cfg.rows) && ({1'b0, cursor_col} < cfg.cols);
    rd_in_screen = ({1'b0, read_row} < cfg.rows) && ({1'b0, read_col} < cfg.cols);
    put_addr     = CW'(CW'(cursor_row) * CW'(cfg.cols)) + CW'(cursor_col);
    rd_addr      = CW'(CW'(read_row) * CW'(cfg.cols)) + CW'(read_col);
    issue        = (cp_src < total);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cp_dst[AW-1:0];
    ram_wdata = fill_cell;
    ram_raddr = rd_addr[AW-1:0];
    case (state)
      ST_IDLE: begin
        ram_waddr = put_addr[AW-1:0];
        ram_wdata = {cfg.colour, char_code};
        ram_we    = accept && (command == ttw_pkg::CMD_PUT) && !is_newline && in_screen;
      end
      ST_COPY: begin
        ram_raddr = cp_src[AW-1:0];
        ram_wdata = ram_rdata;
        ram_we    = cp_pend;
      end
      ST_INIT, ST_FILL, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cursor_row <= '0;
      cursor_col <= '0;
      cp_dst     <= '0;
      cp_src     <= '0;
      cp_pend    <= 1'b0;
      fill_cell  <= ttw_pkg::RESET_CELL;
      out_valid  <= 1'b0;
    end else begin
      if ((state == ST_RDW) || (accept && (command != ttw_pkg::CMD_READ))) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT, ST_CLEAR: begin
          if (cp_dst == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            cp_dst <= cp_dst + CW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            fill_cell      <= {cfg.colour, ttw_pkg::BLANK_GLYPH};
            total          <= CW'(CW'(cfg.rows) * CW'(cfg.cols));
            cp_src         <= CW'(cfg.cols);
            cp_dst         <= '0;
            cp_pend        <= 1'b0;
            case (command)
              ttw_pkg::CMD_PUT: begin
                cell_value     <= '0;
                scrolled       <= scroll;
                cursor_row     <= row_next;
                cursor_col     <= col_next;
                cursor_row_out <= row_next;
                cursor_col_out <= col_next;
                if (scroll) begin
                  state <= ST_COPY;
                end
              end
              ttw_pkg::CMD_READ: begin
                scrolled       <= 1'b0;
                cursor_row_out <= cursor_row;
                cursor_col_out <= cursor_col;
                read_ok        <= rd_in_screen;
                state          <= ST_RDW;
              end
              ttw_pkg::CMD_CLEAR: begin
                cell_value     <= '0;
                scrolled       <= 1'b0;
                cursor_row     <= '0;
                cursor_col     <= '0;
                cursor_row_out <= '0;
                cursor_col_out <= '0;
                state          <= ST_CLEAR;
              end
              default: begin
                cell_value     <= '0;
                scrolled       <= 1'b0;
                cursor_row_out <= cursor_row;
                cursor_col_out <= cursor_col;
              end
            endcase
          end
        end
        ST_RDW: begin
          cell_value <= read_ok ? ram_rdata : '0;
          state      <= ST_IDLE;
        end
        ST_COPY: begin
          if (issue) begin
            cp_src <= cp_src + CW'(1);
          end
          cp_pend <= issue;
          if (cp_pend) begin
            cp_dst <= cp_dst + CW'(1);
          end
          if (!issue && !cp_pend) begin
            state <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (cp_dst == total - CW'(1)) begin
            state <= ST_IDLE;
          end else begin
            cp_dst <= cp_dst + CW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
